// File: rtl/sabm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sabm_pkg: shared types and constants
// Constants, state encoding and stream layout for the suffix automaton core.
// ----------------------------------------------------------------------------
package sabm_pkg;

    localparam int MAX_STATES_DEF  = 1024;
    localparam int SYMBOL_BITS_DEF = 8;
    localparam int LEN_W           = 11;
    localparam int CNT_W           = 11;
    localparam logic [LEN_W-1:0] MIN_LEN_RST = 11'd3;
    localparam logic [LEN_W-1:0] LEN_SAT     = 11'h7FF;

    localparam logic MODE_MATCH  = 1'b0;
    localparam logic MODE_EXTEND = 1'b1;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EX_LEN,
        ST_EX_RD,
        ST_EX_CHK,
        ST_EX_LINK,
        ST_EX_QRD,
        ST_EX_QCHK,
        ST_CP_RD,
        ST_CP_WR,
        ST_RD_RD,
        ST_RD_CHK,
        ST_RD_LINK,
        ST_MA_RD,
        ST_MA_CHK,
        ST_MA_LINK,
        ST_OUT
    } state_t;

endpackage : sabm_pkg
`default_nettype wire

// File: rtl/sabm_trans_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sabm_trans_mem: transition table
// One write port, one registered read port; entry is a target state, 0 = none.
// ----------------------------------------------------------------------------
module sabm_trans_mem #(
    parameter int AW = 18,
    parameter int DW = 10
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : sabm_trans_mem
`default_nettype wire

// File: rtl/sabm_node_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sabm_node_mem: per-state length and suffix link
// One write port, one registered read port; {length, link} per entry.
// ----------------------------------------------------------------------------
module sabm_node_mem #(
    parameter int AW = 10,
    parameter int DW = 21
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : sabm_node_mem
`default_nettype wire

// File: rtl/suffix_automaton_build_match_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// suffix_automaton_build_match_core: online suffix automaton build and match
// Operation: match walks suffix links until a transition is found; extend walks
//   links adding transitions, checks the target when a transition already exists,
//   and on a clone copies the row, relinks, then redirects further links.
// Flow: one item at a time; next item accepted once the previous result
//   has been transferred.
// Reset: clearing pass over every transition table entry (node entries
//   alongside) before the first item is taken; config taken any time.
// ----------------------------------------------------------------------------
module suffix_automaton_build_match_core #(
    parameter int MAX_STATES  = sabm_pkg::MAX_STATES_DEF,
    parameter int SYMBOL_BITS = sabm_pkg::SYMBOL_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // mode[0], symbol[8:1], restart[9]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // match_len[10:0], long_match[11],
                                        // store_full[12], states_used[23:13]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data   // min_report_len[10:0]
);

    localparam int SW  = $clog2(MAX_STATES);
    localparam int TAW = SW + SYMBOL_BITS;
    localparam int NW  = sabm_pkg::LEN_W + SW;
    localparam int LW  = sabm_pkg::LEN_W;
    localparam int CW  = SW + 1;
    localparam logic [TAW-1:0] CLR_LAST = {TAW{1'b1}};
    localparam logic [SYMBOL_BITS-1:0] SYM_LAST = {SYMBOL_BITS{1'b1}};
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_STATES);

    sabm_pkg::state_t st_reg, st_next;

    logic [LW-1:0]  min_len_reg;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [SW-1:0]  last_reg, last_next;
    logic [SW-1:0]  cur_reg, cur_next;      // match cursor
    logic [LW-1:0]  mlen_reg, mlen_next;
    logic [SW-1:0]  p_reg, p_next;
    logic [SW-1:0]  q_reg, q_next;
    logic [SW-1:0]  nw_reg, nw_next;        // new state in extend
    logic [SW-1:0]  cl_reg, cl_next;
    logic [LW-1:0]  plen_reg, plen_next;
    logic [SYMBOL_BITS-1:0] sym_reg, sym_next;
    logic [SYMBOL_BITS-1:0] k_reg, k_next;
    logic [TAW-1:0] clr_reg, clr_next;
    logic           full_reg, full_next;
    logic           out_v_reg;
    logic [23:0]    out_d_reg;

    logic           t_we, n_we;
    logic [TAW-1:0] t_wa, t_ra;
    logic [SW-1:0]  t_wd, t_rd;
    logic [SW-1:0]  n_wa, n_ra;
    logic [NW-1:0]  n_wd, n_rd;
    logic [LW-1:0]  n_len;
    logic [SW-1:0]  n_link;
    logic           out_load;
    logic [LW-1:0]  res_len;

    assign n_len  = n_rd[NW-1:SW];
    assign n_link = n_rd[SW-1:0];

    sabm_trans_mem #(.AW(TAW), .DW(SW)) u_trans (
        .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd)
    );

    sabm_node_mem #(.AW(SW), .DW(NW)) u_node (
        .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (st_reg == sabm_pkg::ST_IDLE) && !out_v_reg;
    assign m_tvalid  = out_v_reg;
    assign m_tdata   = out_d_reg;
    assign res_len   = mlen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= sabm_pkg::ST_CLEAR;
            min_len_reg <= sabm_pkg::MIN_LEN_RST;
            cnt_reg     <= CW'(1);
            last_reg    <= '0;
            cur_reg     <= '0;
            mlen_reg    <= '0;
            clr_reg     <= '0;
            full_reg    <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
            cur_reg  <= cur_next;
            mlen_reg <= mlen_next;
            clr_reg  <= clr_next;
            full_reg <= full_next;
            if (cfg_valid)
            begin
                min_len_reg <= cfg_data[LW-1:0];
            end
            if (out_load)
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        q_reg    <= q_next;
        nw_reg   <= nw_next;
        cl_reg   <= cl_next;
        plen_reg <= plen_next;
        sym_reg  <= sym_next;
        k_reg    <= k_next;
        if (out_load)
        begin
            out_d_reg <= {LW'(cnt_reg) & sabm_pkg::LEN_SAT, full_reg,
                          (res_len >= min_len_reg), res_len};
        end
    end

    always_comb
    begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        cur_next  = cur_reg;
        mlen_next = mlen_reg;
        p_next    = p_reg;
        q_next    = q_reg;
        nw_next   = nw_reg;
        cl_next   = cl_reg;
        plen_next = plen_reg;
        sym_next  = sym_reg;
        k_next    = k_reg;
        clr_next  = clr_reg;
        full_next = full_reg;
        out_load  = 1'b0;
        t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
        n_we = 1'b0; n_wa = '0; n_wd = '0; n_ra = '0;
        case (st_reg)
            sabm_pkg::ST_CLEAR:
            begin
                t_we = 1'b1;
                t_wa = clr_reg;
                n_we = 1'b1;
                n_wa = clr_reg[SW-1:0];
                clr_next = clr_reg + TAW'(1);
                if (clr_reg == CLR_LAST)
                begin
                    st_next = sabm_pkg::ST_IDLE;
                end
            end
            sabm_pkg::ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    sym_next  = s_tdata[SYMBOL_BITS:1];
                    full_next = 1'b0;
                    if (s_tdata[9])
                    begin
                        cur_next  = '0;
                        mlen_next = '0;
                    end
                    if (s_tdata[0] == sabm_pkg::MODE_EXTEND)
                    begin
                        if (cnt_reg + CW'(2) > MAX_CNT)
                        begin
                            full_next = 1'b1;
                            st_next   = sabm_pkg::ST_OUT;
                        end
                        else
                        begin
                            nw_next  = cnt_reg[SW-1:0];
                            cnt_next = cnt_reg + CW'(1);
                            p_next   = last_reg;
                            n_ra     = last_reg;
                            st_next  = sabm_pkg::ST_EX_LEN;
                        end
                    end
                    else
                    begin
                        p_next  = s_tvalid && s_tdata[9] ? '0 : cur_reg;
                        st_next = sabm_pkg::ST_MA_RD;
                    end
                end
            end
            sabm_pkg::ST_EX_LEN:
            begin
                // length of new state; link left at root (0) unless set later
                n_we = 1'b1;
                n_wa = nw_reg;
                n_wd = {n_len + LW'(1), {SW{1'b0}}};
                st_next = sabm_pkg::ST_EX_RD;
            end
            sabm_pkg::ST_EX_RD:
            begin
                t_ra = {p_reg, sym_reg};
                n_ra = p_reg;
                st_next = sabm_pkg::ST_EX_CHK;
            end
            sabm_pkg::ST_EX_CHK:
            begin
                if (t_rd != '0)
                begin
                    q_next    = t_rd;
                    plen_next = n_len;
                    n_ra      = t_rd;
                    st_next   = sabm_pkg::ST_EX_QRD;
                end
                else
                begin
                    t_we = 1'b1;
                    t_wa = {p_reg, sym_reg};
                    t_wd = nw_reg;
                    if (p_reg == '0)
                    begin
                        last_next = nw_reg;
                        st_next   = sabm_pkg::ST_OUT;
                    end
                    else
                    begin
                        p_next  = n_link;
                        st_next = sabm_pkg::ST_EX_RD;
                    end
                end
            end
            sabm_pkg::ST_EX_QRD:
            begin
                n_ra    = q_reg;
                st_next = sabm_pkg::ST_EX_QCHK;
            end
            sabm_pkg::ST_EX_QCHK:
            begin
                if (plen_reg + LW'(1) == n_len)
                begin
                    // fetch new state so its length survives the link write
                    n_ra      = nw_reg;
                    last_next = nw_reg;
                    st_next   = sabm_pkg::ST_EX_LINK;
                end
                else
                begin
                    n_we     = 1'b1;
                    cl_next  = cnt_reg[SW-1:0];
                    cnt_next = cnt_reg + CW'(1);
                    n_wa = cnt_reg[SW-1:0];
                    n_wd = {plen_reg + LW'(1), n_link};
                    k_next  = '0;
                    st_next = sabm_pkg::ST_CP_RD;
                end
            end
            sabm_pkg::ST_EX_LINK:
            begin
                n_we = 1'b1;
                n_wa = nw_reg;
                n_wd = {n_len, q_reg};
                st_next = sabm_pkg::ST_OUT;
            end
            sabm_pkg::ST_CP_RD:
            begin
                t_ra = {q_reg, k_reg};
                st_next = sabm_pkg::ST_CP_WR;
            end
            sabm_pkg::ST_CP_WR:
            begin
                t_we = 1'b1;
                t_wa = {cl_reg, k_reg};
                t_wd = t_rd;
                k_next = k_reg + SYMBOL_BITS'(1);
                n_ra = q_reg;
                if (k_reg == SYM_LAST)
                begin
                    st_next = sabm_pkg::ST_RD_RD;
                end
                else
                begin
                    st_next = sabm_pkg::ST_CP_RD;
                end
            end
            sabm_pkg::ST_RD_RD:
            begin
                // n_rd holds q entry; relink q to clone
                n_we = 1'b1;
                n_wa = q_reg;
                n_wd = {n_len, cl_reg};
                t_ra = {p_reg, sym_reg};
                n_ra = p_reg;
                st_next = sabm_pkg::ST_RD_CHK;
            end
            sabm_pkg::ST_RD_CHK:
            begin
                if (t_rd != q_reg)
                begin
                    st_next = sabm_pkg::ST_RD_LINK;
                    n_ra    = nw_reg;
                end
                else
                begin
                    t_we = 1'b1;
                    t_wa = {p_reg, sym_reg};
                    t_wd = cl_reg;
                    if (p_reg == '0)
                    begin
                        st_next = sabm_pkg::ST_RD_LINK;
                        n_ra    = nw_reg;
                    end
                    else
                    begin
                        p_next  = n_link;
                        n_ra    = q_reg;
                        st_next = sabm_pkg::ST_RD_RD;
                    end
                end
            end
            sabm_pkg::ST_RD_LINK:
            begin
                n_we = 1'b1;
                n_wa = nw_reg;
                n_wd = {n_len, cl_reg};
                last_next = nw_reg;
                st_next   = sabm_pkg::ST_OUT;
            end
            sabm_pkg::ST_MA_RD:
            begin
                t_ra = {p_reg, sym_reg};
                n_ra = p_reg;
                st_next = sabm_pkg::ST_MA_CHK;
            end
            sabm_pkg::ST_MA_CHK:
            begin
                if (t_rd != '0)
                begin
                    cur_next  = t_rd;
                    mlen_next = (mlen_reg == sabm_pkg::LEN_SAT) ? mlen_reg
                                                                : mlen_reg + LW'(1);
                    st_next   = sabm_pkg::ST_OUT;
                end
                else if (p_reg == '0)
                begin
                    cur_next = '0;
                    st_next  = sabm_pkg::ST_OUT;
                end
                else
                begin
                    p_next  = n_link;
                    n_ra    = n_link;
                    st_next = sabm_pkg::ST_MA_LINK;
                end
            end
            sabm_pkg::ST_MA_LINK:
            begin
                mlen_next = n_len;
                st_next   = sabm_pkg::ST_MA_RD;
            end
            sabm_pkg::ST_OUT:
            begin
                if (!out_v_reg)
                begin
                    out_load = 1'b1;
                    st_next  = sabm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                st_next = sabm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule : suffix_automaton_build_match_core
`default_nettype wire

// File: rtl/sabm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sabm_checker: port-level checks
// Watches the stream ports of the core over time.
// ----------------------------------------------------------------------------
module sabm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken before result");

    a_used_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:13] != 11'd0)
        else $error("states_used zero");

    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

endmodule : sabm_checker

bind suffix_automaton_build_match_core sabm_checker u_sabm_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
